FILE: src/esd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, constants and the summing sequence table for the
// elevator-family seek distance block.
// ----------------------------------------------------------------------------
package esd_pkg;

    localparam int MAX_REQUESTS = 64;
    localparam int CYL_BITS     = 16;
    localparam int DIST_BITS    = 18;
    localparam int ADDR_BITS    = $clog2(MAX_REQUESTS);
    localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);
    localparam int MAX_STEPS    = 6;
    localparam int STEP_BITS    = $clog2(MAX_STEPS);
    localparam int CFG_ADDR_BITS = 2;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SCAN_MODE       = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_CYLINDER_COUNT  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_POSITION  = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_DIRECTION = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef enum logic [1:0] {
        MODE_SCAN,
        MODE_CSCAN,
        MODE_LOOK,
        MODE_CLOOK
    } mode_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OPND_ZERO,
        OPND_S,
        OPND_EDGE,
        OPND_FAR,
        OPND_BMIN,
        OPND_BMAX
    } opnd_t;

    typedef struct packed {
        opnd_t sel;
        logic  sub;
    } step_t;

    // operand and sign for step k of the distance sum
    function automatic step_t step_op(mode_t mode, logic up, logic have_b,
                                      logic [STEP_BITS-1:0] k);
        opnd_t                seq [MAX_STEPS];
        logic [MAX_STEPS-1:0] neg;
        step_t                op;
        for (int i = 0; i < MAX_STEPS; i++) begin
            seq[i] = OPND_ZERO;
        end
        neg = '0;
        if (!have_b) begin
            if (up) begin
                seq[0] = OPND_FAR; seq[1] = OPND_S; neg[1] = 1'b1;
            end else begin
                seq[0] = OPND_S; seq[1] = OPND_FAR; neg[1] = 1'b1;
            end
        end else begin
            case (mode)
                MODE_SCAN: begin
                    if (up) begin
                        seq[0] = OPND_EDGE; seq[1] = OPND_S;    neg[1] = 1'b1;
                        seq[2] = OPND_EDGE; seq[3] = OPND_BMIN; neg[3] = 1'b1;
                    end else begin
                        seq[0] = OPND_S; seq[1] = OPND_BMAX;
                    end
                end
                MODE_CSCAN: begin
                    if (up) begin
                        seq[0] = OPND_EDGE; seq[1] = OPND_S; neg[1] = 1'b1;
                        seq[2] = OPND_EDGE; seq[3] = OPND_BMAX;
                    end else begin
                        seq[0] = OPND_S;    seq[1] = OPND_EDGE;
                        seq[2] = OPND_EDGE; seq[3] = OPND_BMIN; neg[3] = 1'b1;
                    end
                end
                MODE_LOOK: begin
                    if (up) begin
                        seq[0] = OPND_FAR; seq[1] = OPND_S;    neg[1] = 1'b1;
                        seq[2] = OPND_FAR; seq[3] = OPND_BMIN; neg[3] = 1'b1;
                    end else begin
                        seq[0] = OPND_S;    seq[1] = OPND_FAR; neg[1] = 1'b1;
                        seq[2] = OPND_BMAX; seq[3] = OPND_FAR; neg[3] = 1'b1;
                    end
                end
                default: begin
                    if (up) begin
                        seq[0] = OPND_FAR;  seq[1] = OPND_S;    neg[1] = 1'b1;
                        seq[2] = OPND_FAR;  seq[3] = OPND_BMIN; neg[3] = 1'b1;
                        seq[4] = OPND_BMAX; seq[5] = OPND_BMIN; neg[5] = 1'b1;
                    end else begin
                        seq[0] = OPND_S;    seq[1] = OPND_FAR;  neg[1] = 1'b1;
                        seq[2] = OPND_BMAX; seq[3] = OPND_FAR;  neg[3] = 1'b1;
                        seq[4] = OPND_BMAX; seq[5] = OPND_BMIN; neg[5] = 1'b1;
                    end
                end
            endcase
        end
        if (k < STEP_BITS'(MAX_STEPS)) begin
            op.sel = seq[k];
            op.sub = neg[k];
        end else begin
            op.sel = OPND_ZERO;
            op.sub = 1'b0;
        end
        return op;
    endfunction

endpackage

FILE: src/elevator_scan_seek_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevator_scan_seek_distance
// Stores a batch of cylinder requests, then walks the stored batch and sums
// the head travel for SCAN, C-SCAN, LOOK or C-LOOK with one shared adder.
// ----------------------------------------------------------------------------
// sequence: requests load one per cycle while s_ready is high; after the last
//   item the stored batch is read back one request per cycle, then six adder
//   steps run before the result is valid
// throughput: one batch at a time, not ready from last item until result taken
// reset: synchronous active-low aresetn clears the batch and loads the
//   register reset values
module elevator_scan_seek_distance (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [esd_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [esd_pkg::CYL_BITS-1:0]        cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [esd_pkg::CYL_BITS-1:0]        s_request_cylinder,
    input  logic                                s_last_request,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [esd_pkg::DIST_BITS-1:0]       m_total_distance,
    output logic [1:0]                          m_status
);

    localparam int CB = esd_pkg::CYL_BITS;
    localparam int DB = esd_pkg::DIST_BITS;

    // configuration
    esd_pkg::mode_t  scan_mode_reg;
    logic [CB-1:0]   cylinder_count_reg;
    logic [CB-1:0]   start_position_reg;
    logic            start_direction_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode_reg       <= esd_pkg::MODE_SCAN;
            cylinder_count_reg  <= CB'(200);
            start_position_reg  <= '0;
            start_direction_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                esd_pkg::REG_SCAN_MODE:       scan_mode_reg <= esd_pkg::mode_t'(cfg_wdata[1:0]);
                esd_pkg::REG_CYLINDER_COUNT:  cylinder_count_reg <= cfg_wdata;
                esd_pkg::REG_START_POSITION:  start_position_reg <= cfg_wdata;
                esd_pkg::REG_START_DIRECTION: start_direction_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // request store
    logic [CB-1:0] mem [esd_pkg::MAX_REQUESTS];
    logic [CB-1:0] mem_q;

    esd_pkg::state_t               state_reg, state_next;
    logic [esd_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [esd_pkg::CNT_BITS-1:0]  idx_reg, idx_next;
    logic                          rd_vld_reg, rd_vld_next;
    logic                          bad_reg, bad_next;
    logic                          full_reg, full_next;
    logic [CB-1:0]                 s_pos_reg, s_pos_next;
    logic [CB-1:0]                 edge_reg, edge_next;
    logic                          up_reg, up_next;
    logic [CB-1:0]                 far_reg, far_next;
    logic [CB-1:0]                 bmin_reg, bmin_next;
    logic [CB-1:0]                 bmax_reg, bmax_next;
    logic                          have_b_reg, have_b_next;
    logic [esd_pkg::STEP_BITS-1:0] k_reg, k_next;
    logic [DB-1:0]                 acc_reg, acc_next;
    logic                          m_valid_reg, m_valid_next;
    logic [DB-1:0]                 dist_reg, dist_next;
    logic [1:0]                    status_reg, status_next;

    logic          in_acc;
    logic          store_ok;
    logic          issue;
    logic          scan_done;
    logic          r_ahead;
    logic [CB-1:0] edge_c;
    logic [CB-1:0] s_clamp;
    esd_pkg::step_t op;
    logic [DB-1:0] opnd;
    logic [DB-1:0] sum;
    logic [1:0]    status_c;

    assign in_acc    = s_valid && s_ready;
    assign store_ok  = cnt_reg < esd_pkg::CNT_BITS'(esd_pkg::MAX_REQUESTS);
    assign issue     = (state_reg == esd_pkg::ST_SCAN) && (idx_reg < cnt_reg);
    assign scan_done = !issue && !rd_vld_reg;
    assign edge_c    = cylinder_count_reg - CB'(1);
    assign s_clamp   = (start_position_reg > edge_c) ? edge_c : start_position_reg;
    assign r_ahead   = up_reg ? (mem_q >= s_pos_reg) : (mem_q <= s_pos_reg);

    always_ff @(posedge aclk) begin
        if (in_acc && store_ok) begin
            mem[cnt_reg[esd_pkg::ADDR_BITS-1:0]] <= s_request_cylinder;
        end
        if (issue) begin
            mem_q <= mem[idx_reg[esd_pkg::ADDR_BITS-1:0]];
        end
    end

    // shared add/subtract unit
    assign op = esd_pkg::step_op(scan_mode_reg, up_reg, have_b_reg, k_reg);

    always_comb begin
        case (op.sel)
            esd_pkg::OPND_S:    opnd = DB'(s_pos_reg);
            esd_pkg::OPND_EDGE: opnd = DB'(edge_reg);
            esd_pkg::OPND_FAR:  opnd = DB'(far_reg);
            esd_pkg::OPND_BMIN: opnd = DB'(bmin_reg);
            esd_pkg::OPND_BMAX: opnd = DB'(bmax_reg);
            default:            opnd = '0;
        endcase
    end

    assign sum = op.sub ? (acc_reg - opnd) : (acc_reg + opnd);

    always_comb begin
        if (bad_reg) begin
            status_c = esd_pkg::STATUS_BAD;
        end else if (full_reg) begin
            status_c = esd_pkg::STATUS_FULL;
        end else begin
            status_c = esd_pkg::STATUS_OK;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            esd_pkg::ST_LOAD: begin
                if (in_acc && s_last_request) begin
                    state_next = esd_pkg::ST_SCAN;
                end
            end
            esd_pkg::ST_SCAN: begin
                if (scan_done) begin
                    state_next = esd_pkg::ST_SUM;
                end
            end
            esd_pkg::ST_SUM: begin
                if (k_reg == esd_pkg::STEP_BITS'(esd_pkg::MAX_STEPS - 1)) begin
                    state_next = esd_pkg::ST_OUT;
                end
            end
            esd_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = esd_pkg::ST_LOAD;
                end
            end
            default: state_next = esd_pkg::ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        rd_vld_next  = 1'b0;
        bad_next     = bad_reg;
        full_next    = full_reg;
        s_pos_next   = s_pos_reg;
        edge_next    = edge_reg;
        up_next      = up_reg;
        far_next     = far_reg;
        bmin_next    = bmin_reg;
        bmax_next    = bmax_reg;
        have_b_next  = have_b_reg;
        k_next       = k_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg;
        dist_next    = dist_reg;
        status_next  = status_reg;
        case (state_reg)
            esd_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (store_ok) begin
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        full_next = 1'b1;
                    end
                    if (s_last_request) begin
                        idx_next    = '0;
                        s_pos_next  = s_clamp;
                        edge_next   = edge_c;
                        up_next     = start_direction_reg;
                        far_next    = s_clamp;
                        have_b_next = 1'b0;
                    end
                end
            end
            esd_pkg::ST_SCAN: begin
                rd_vld_next = issue;
                if (issue) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    if (mem_q >= cylinder_count_reg) begin
                        bad_next = 1'b1;
                    end
                    if (r_ahead) begin
                        if (up_reg && mem_q > far_reg) begin
                            far_next = mem_q;
                        end
                        if (!up_reg && mem_q < far_reg) begin
                            far_next = mem_q;
                        end
                    end else begin
                        if (!have_b_reg || mem_q < bmin_reg) begin
                            bmin_next = mem_q;
                        end
                        if (!have_b_reg || mem_q > bmax_reg) begin
                            bmax_next = mem_q;
                        end
                        have_b_next = 1'b1;
                    end
                end
                if (scan_done) begin
                    k_next   = '0;
                    acc_next = '0;
                    if (cnt_reg == '0 && !full_reg) begin
                        bad_next = 1'b1;
                    end
                end
            end
            esd_pkg::ST_SUM: begin
                acc_next = sum;
                k_next   = k_reg + 1'b1;
                if (k_reg == esd_pkg::STEP_BITS'(esd_pkg::MAX_STEPS - 1)) begin
                    m_valid_next = 1'b1;
                    status_next  = status_c;
                    dist_next    = (status_c == esd_pkg::STATUS_OK) ? sum : '0;
                end
            end
            esd_pkg::ST_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    cnt_next     = '0;
                    bad_next     = 1'b0;
                    full_next    = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= esd_pkg::ST_LOAD;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            bad_reg     <= 1'b0;
            full_reg    <= 1'b0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            rd_vld_reg  <= rd_vld_next;
            bad_reg     <= bad_next;
            full_reg    <= full_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_pos_reg  <= s_pos_next;
        edge_reg   <= edge_next;
        up_reg     <= up_next;
        far_reg    <= far_next;
        bmin_reg   <= bmin_next;
        bmax_reg   <= bmax_next;
        have_b_reg <= have_b_next;
        acc_reg    <= acc_next;
        dist_reg   <= dist_next;
        status_reg <= status_next;
    end

    assign s_ready          = (state_reg == esd_pkg::ST_LOAD);
    assign m_valid          = m_valid_reg;
    assign m_total_distance = dist_reg;
    assign m_status         = status_reg;

endmodule
